// ----- src/grid_potential_interpolator_unit_assert.svh -----
// Assertion macros shared by the interpolator RTL
// Needs clk and rst in the scope where a macro is used; no other dependencies
`ifndef GRID_POTENTIAL_INTERPOLATOR_UNIT_ASSERT_SVH
`define GRID_POTENTIAL_INTERPOLATOR_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// condition holds at every clock edge out of reset
`define GPI_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("gpi invariant violated");

// consequent holds in the same cycle as the antecedent
`define GPI_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gpi implication violated");

`else

`define GPI_ASSERT_ALWAYS(label, cond)
`define GPI_ASSERT_IMPLIES(label, ante, cons)

`endif

`endif

// ----- src/gpi_pkg.sv -----
// Types and fixed-point constants for the grid potential interpolator
// No dependencies; imported by grid_potential_interpolator_unit
package gpi_pkg;

  // field and datapath widths
  localparam int ADDR_W     = 15;
  localparam int VAL_W      = 24;
  localparam int COORD_W    = 32;
  localparam int RECIP_W    = 24;
  localparam int LIMIT_W    = 23;
  localparam int FRAC_W     = 16;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int PROD_LO_W  = FRAC_W + RECIP_W;
  localparam int PROD_HI_W  = (DIFF_W - FRAC_W) + RECIP_W + 1;
  localparam int U_W        = PROD_HI_W + FRAC_W;
  localparam int IDX_W      = U_W - 32;
  localparam int COEF_W     = FRAC_W + 3;
  localparam int MUL_W      = VAL_W + COEF_W;
  localparam int ACC_W      = MUL_W + 2;
  localparam int ROUND_W    = ACC_W - FRAC_W;
  localparam int NUM_AXES   = 3;
  localparam int NUM_GRIDS  = 3;
  localparam int NUM_SLOTS  = 4;
  localparam int SLOT_W     = 2;
  localparam int MEM_W      = NUM_GRIDS * VAL_W;

  // result buffer
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = 2;
  localparam int FIFO_CNT_W = 3;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // fixed-point constants
  localparam int ONE_Q16    = 65536;
  localparam int ROUND_HALF = 32768;

  // register reset values
  localparam logic [COORD_W-1:0] ORIGIN_TIME_RST = 32'h0000_0000;
  localparam logic [COORD_W-1:0] ORIGIN_X_RST    = 32'hFFF3_0000;
  localparam logic [COORD_W-1:0] ORIGIN_Y_RST    = 32'hFFF3_0000;
  localparam logic [RECIP_W-1:0] RECIP_TIME_RST  = 24'd3276800;
  localparam logic [RECIP_W-1:0] RECIP_X_RST     = 24'd655360;
  localparam logic [RECIP_W-1:0] RECIP_Y_RST     = 24'd655360;
  localparam logic [LIMIT_W-1:0] CLAMP_LIMIT_RST = 23'd6554;

  typedef enum logic {
    KIND_LOAD  = 1'b0,
    KIND_QUERY = 1'b1
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_TIME     = 3'd0,
    REG_ORIGIN_X        = 3'd1,
    REG_ORIGIN_Y        = 3'd2,
    REG_RECIP_TIME_STEP = 3'd3,
    REG_RECIP_X_STEP    = 3'd4,
    REG_RECIP_Y_STEP    = 3'd5,
    REG_CLAMP_LIMIT     = 3'd6
  } reg_index_t;

  typedef struct packed {
    kind_t                     kind;
    logic [ADDR_W-1:0]         entry_address;
    logic signed [VAL_W-1:0]   load_up;
    logic signed [VAL_W-1:0]   load_down;
    logic signed [VAL_W-1:0]   load_strange;
    logic signed [COORD_W-1:0] query_time;
    logic signed [COORD_W-1:0] query_x;
    logic signed [COORD_W-1:0] query_y;
  } in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] result_up;
    logic signed [VAL_W-1:0] result_down;
    logic signed [VAL_W-1:0] result_strange;
    logic                    inside_grid;
  } out_t;

  // the part of an item that travels past the coordinate stages
  typedef struct packed {
    kind_t             kind;
    logic [ADDR_W-1:0] entry_address;
    logic [MEM_W-1:0]  values;
  } load_t;

endpackage

// ----- src/grid_potential_interpolator_unit.sv -----
// Grid potential interpolator: coordinate pipeline, grid memory sequencer, result buffer
// Depends on gpi_pkg and grid_potential_interpolator_unit_assert.svh
//
//   channel  | direction | handshake              | beat
//   item     | in        | item_valid/item_stall  | in_t: load or query
//   result   | out       | result_valid/result_stall | out_t: one per query
//   cfg      | in        | cfg_valid/cfg_ready    | cfg_index, cfg_data
//
// A load takes a single grid memory write, an inside query four reads (base point and three
// forward neighbours from one single-ported memory), an outside query no memory access.
// Items overlap in the pipeline.
// rst is synchronous; it restores the register reset values, the grid memory is not cleared.
// A stalled result port fills a 4-beat buffer, after which queries wait in the memory stage.
`include "grid_potential_interpolator_unit_assert.svh"

module grid_potential_interpolator_unit
  import gpi_pkg::*;
#(
  parameter int GRID_T = 8,
  parameter int GRID_X = 64,
  parameter int GRID_Y = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_stall,
  input  in_t                   item,
  output logic                  result_valid,
  input  logic                  result_stall,
  output out_t                  result,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int IT_W = $clog2(GRID_T);
  localparam int IX_W = $clog2(GRID_X);
  localparam int IY_W = $clog2(GRID_Y);
  localparam int MEM_DEPTH = 1 << ADDR_W;
  localparam logic [ADDR_W-1:0] XY_STEP = ADDR_W'((GRID_X * GRID_Y) % MEM_DEPTH);
  localparam logic [ADDR_W-1:0] Y_STEP  = ADDR_W'(GRID_Y % MEM_DEPTH);
  localparam logic [IDX_W-1:0] IDX_LIMIT [NUM_AXES] =
    '{IDX_W'(GRID_T - 1), IDX_W'(GRID_X - 1), IDX_W'(GRID_Y - 1)};

  // configuration registers
  logic signed [COORD_W-1:0] origin [NUM_AXES];
  logic [RECIP_W-1:0]        recip [NUM_AXES];
  logic [LIMIT_W-1:0]        clamp_limit;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin[0]   <= ORIGIN_TIME_RST;
      origin[1]   <= ORIGIN_X_RST;
      origin[2]   <= ORIGIN_Y_RST;
      recip[0]    <= RECIP_TIME_RST;
      recip[1]    <= RECIP_X_RST;
      recip[2]    <= RECIP_Y_RST;
      clamp_limit <= CLAMP_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ORIGIN_TIME:     origin[0]   <= cfg_data;
        REG_ORIGIN_X:        origin[1]   <= cfg_data;
        REG_ORIGIN_Y:        origin[2]   <= cfg_data;
        REG_RECIP_TIME_STEP: recip[0]    <= cfg_data[RECIP_W-1:0];
        REG_RECIP_X_STEP:    recip[1]    <= cfg_data[RECIP_W-1:0];
        REG_RECIP_Y_STEP:    recip[2]    <= cfg_data[RECIP_W-1:0];
        REG_CLAMP_LIMIT:     clamp_limit <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline registers
  logic                      s1_valid, s2_valid, s3_valid, s4_valid, m_valid;
  load_t                     s1_load, s2_load, s3_load, s4_load, m_load;
  logic signed [DIFF_W-1:0]  s1_d [NUM_AXES];
  logic [PROD_LO_W-1:0]      s2_plo [NUM_AXES];
  logic signed [PROD_HI_W-1:0] s2_phi [NUM_AXES];
  logic                      s3_ok, s4_ok, m_ok;
  logic [IT_W-1:0]           s3_it;
  logic [IX_W-1:0]           s3_ix;
  logic [IY_W-1:0]           s3_iy;
  logic [FRAC_W-1:0]         s3_frac [NUM_AXES];
  logic [ADDR_W-1:0]         s4_addr [NUM_SLOTS];
  logic [ADDR_W-1:0]         m_addr [NUM_SLOTS];
  logic signed [COEF_W-1:0]  s4_coef [NUM_SLOTS];
  logic signed [COEF_W-1:0]  m_coef [NUM_SLOTS];
  logic [SLOT_W-1:0]         m_step;

  // stage advance chain, back from the memory stage
  logic m_query, m_act, m_last, m_done, credit;
  logic m_take, s4_take, s3_take, s2_take, s1_take;

  assign m_take  = !m_valid || m_done;
  assign s4_take = !s4_valid || m_take;
  assign s3_take = !s3_valid || s4_take;
  assign s2_take = !s2_valid || s3_take;
  assign s1_take = !s1_valid || s2_take;
  assign item_stall = !s1_take;

  // input beat: offset from origin per axis
  logic signed [COORD_W-1:0] q [NUM_AXES];
  assign q[0] = item.query_time;
  assign q[1] = item.query_x;
  assign q[2] = item.query_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_take) begin
      s1_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take) begin
      s1_load.kind          <= item.kind;
      s1_load.entry_address <= item.entry_address;
      s1_load.values        <= {item.load_strange, item.load_down, item.load_up};
      for (int a = 0; a < NUM_AXES; a++) begin
        s1_d[a] <= DIFF_W'(q[a]) - DIFF_W'(origin[a]);
      end
    end
  end

  // scale to grid units: offset split into two partial products
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_take) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_take) begin
      s2_load <= s1_load;
      for (int a = 0; a < NUM_AXES; a++) begin
        s2_plo[a] <= s1_d[a][FRAC_W-1:0] * recip[a];
        s2_phi[a] <= $signed(s1_d[a][DIFF_W-1:FRAC_W]) * $signed({1'b0, recip[a]});
      end
    end
  end

  // join partial products, split into index and fraction, range check
  logic [U_W-1:0]   s3_u [NUM_AXES];
  logic [IDX_W-1:0] s3_idx [NUM_AXES];
  logic             s3_axis_ok [NUM_AXES];

  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      s3_u[a]       = {s2_phi[a], {FRAC_W{1'b0}}}
                      + {{(U_W - PROD_LO_W){1'b0}}, s2_plo[a]};
      s3_idx[a]     = s3_u[a][U_W-1:32];
      s3_axis_ok[a] = !s3_u[a][U_W-1] && (s3_idx[a] < IDX_LIMIT[a]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (s3_take) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_take) begin
      s3_load <= s2_load;
      s3_ok   <= s3_axis_ok[0] && s3_axis_ok[1] && s3_axis_ok[2];
      s3_it   <= s3_idx[0][IT_W-1:0];
      s3_ix   <= s3_idx[1][IX_W-1:0];
      s3_iy   <= s3_idx[2][IY_W-1:0];
      for (int a = 0; a < NUM_AXES; a++) begin
        s3_frac[a] <= s3_u[a][31:16];
      end
    end
  end

  // flat addresses of base and forward neighbours, per-slot weights
  logic [ADDR_W-1:0]        s4_base;
  logic [ADDR_W-1:0]        s4_addr_next [NUM_SLOTS];
  logic signed [COEF_W-1:0] s4_coef_next [NUM_SLOTS];

  always_comb begin
    s4_base = ADDR_W'(32'(s3_it) * 32'(XY_STEP)) + ADDR_W'(32'(s3_ix) * 32'(Y_STEP))
              + ADDR_W'(s3_iy);
    s4_addr_next[0] = s4_base;
    s4_addr_next[1] = s4_base + XY_STEP;
    s4_addr_next[2] = s4_base + Y_STEP;
    s4_addr_next[3] = s4_base + ADDR_W'(1);
    // base weight is one minus the sum of the fractions
    s4_coef_next[0] = COEF_W'(ONE_Q16) - $signed({3'b0, s3_frac[0]})
                      - $signed({3'b0, s3_frac[1]}) - $signed({3'b0, s3_frac[2]});
    s4_coef_next[1] = $signed({3'b0, s3_frac[0]});
    s4_coef_next[2] = $signed({3'b0, s3_frac[1]});
    s4_coef_next[3] = $signed({3'b0, s3_frac[2]});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (s4_take) begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s4_take) begin
      s4_load <= s3_load;
      s4_ok   <= s3_ok;
      s4_addr <= s4_addr_next;
      s4_coef <= s4_coef_next;
    end
  end

  // memory stage: one beat of grid access per cycle, held while a new query has no result buffer credit
  logic [FIFO_CNT_W-1:0] reserved, reserved_next;
  logic [FIFO_CNT_W-1:0] fifo_count;
  logic                  reserve, pop;

  assign m_query = (m_load.kind == KIND_QUERY);
  assign credit  = (reserved < FIFO_CNT_W'(FIFO_DEPTH));
  assign m_act   = m_valid && (!m_query || (m_step != '0) || credit);
  assign m_last  = !m_query || !m_ok || (m_step == SLOT_W'(NUM_SLOTS - 1));
  assign m_done  = m_act && m_last;
  assign reserve = m_act && m_query && (m_step == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
      m_step  <= '0;
    end else if (m_take) begin
      m_valid <= s4_valid;
      m_step  <= '0;
    end else if (m_act) begin
      m_step  <= m_step + SLOT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (m_take) begin
      m_load <= s4_load;
      m_ok   <= s4_ok;
      m_addr <= s4_addr;
      m_coef <= s4_coef;
    end
  end

  // grid memory: up, down, strange side by side in one word
  logic [MEM_W-1:0]  grid_mem [MEM_DEPTH];
  logic [MEM_W-1:0]  mem_rdata;
  logic [ADDR_W-1:0] mem_addr;
  logic              mem_we, mem_re;

  assign mem_we   = m_act && !m_query;
  assign mem_re   = m_act && m_query && m_ok;
  assign mem_addr = m_query ? m_addr[m_step] : m_load.entry_address;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      grid_mem[mem_addr] <= m_load.values;
    end
    if (mem_re) begin
      mem_rdata <= grid_mem[mem_addr];
    end
  end

  // beat tags ride alongside the read data at fixed latency
  logic                     t1_valid, t1_first, t1_last, t1_zero;
  logic signed [COEF_W-1:0] t1_coef;

  always_ff @(posedge clk) begin
    if (rst) begin
      t1_valid <= 1'b0;
    end else begin
      t1_valid <= m_act && m_query;
    end
  end

  always_ff @(posedge clk) begin
    t1_first <= (m_step == '0);
    t1_last  <= m_last;
    t1_zero  <= !m_ok;
    t1_coef  <= m_coef[m_step];
  end

  // weight each read value
  logic signed [VAL_W-1:0] rd_lane [NUM_GRIDS];
  logic                    p_valid, p_first, p_last, p_zero;
  logic signed [MUL_W-1:0] p_prod [NUM_GRIDS];

  always_comb begin
    for (int g = 0; g < NUM_GRIDS; g++) begin
      rd_lane[g] = mem_rdata[g*VAL_W +: VAL_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else begin
      p_valid <= t1_valid;
    end
  end

  always_ff @(posedge clk) begin
    p_first <= t1_first;
    p_last  <= t1_last;
    p_zero  <= t1_zero;
    for (int g = 0; g < NUM_GRIDS; g++) begin
      p_prod[g] <= rd_lane[g] * t1_coef;
    end
  end

  // accumulate the weighted terms of a query, four for an inside query
  logic                    a_valid, a_zero;
  logic signed [ACC_W-1:0] acc [NUM_GRIDS];

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= p_valid && p_last;
    end
  end

  always_ff @(posedge clk) begin
    if (p_valid) begin
      a_zero <= p_zero;
      for (int g = 0; g < NUM_GRIDS; g++) begin
        acc[g] <= (p_first ? ACC_W'(0) : acc[g])
                  + {{(ACC_W - MUL_W){p_prod[g][MUL_W-1]}}, p_prod[g]};
      end
    end
  end

  // round half up to Q8.16
  logic                      r_valid, r_zero;
  logic signed [ROUND_W-1:0] r_val [NUM_GRIDS];
  logic signed [ACC_W-1:0]   acc_rnd [NUM_GRIDS];

  always_comb begin
    for (int g = 0; g < NUM_GRIDS; g++) begin
      acc_rnd[g] = acc[g] + ACC_W'(ROUND_HALF);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else begin
      r_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    r_zero <= a_zero;
    for (int g = 0; g < NUM_GRIDS; g++) begin
      r_val[g] <= acc_rnd[g][ACC_W-1:FRAC_W];
    end
  end

  // clamp to the symmetric limit, outside points give zero
  logic signed [ROUND_W-1:0] lim_pos, lim_neg;
  logic signed [VAL_W-1:0]   clamped [NUM_GRIDS];
  out_t                      fifo_wdata;

  assign lim_pos = $signed({{(ROUND_W - LIMIT_W){1'b0}}, clamp_limit});
  assign lim_neg = -lim_pos;

  always_comb begin
    for (int g = 0; g < NUM_GRIDS; g++) begin
      if (r_zero) begin
        clamped[g] = '0;
      end else if (r_val[g] > lim_pos) begin
        clamped[g] = lim_pos[VAL_W-1:0];
      end else if (r_val[g] < lim_neg) begin
        clamped[g] = lim_neg[VAL_W-1:0];
      end else begin
        clamped[g] = r_val[g][VAL_W-1:0];
      end
    end
    fifo_wdata.result_up      = clamped[0];
    fifo_wdata.result_down    = clamped[1];
    fifo_wdata.result_strange = clamped[2];
    fifo_wdata.inside_grid    = !r_zero;
  end

  // result buffer, sized by the credit count so it never overflows
  out_t                  fifo_mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr, rd_ptr;

  assign result_valid = (fifo_count != '0);
  assign result       = fifo_mem[rd_ptr];
  assign pop          = result_valid && !result_stall;

  always_ff @(posedge clk) begin
    if (r_valid) begin
      fifo_mem[wr_ptr] <= fifo_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      fifo_count <= '0;
    end else begin
      if (r_valid) begin
        wr_ptr <= wr_ptr + FIFO_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_PTR_W'(1);
      end
      fifo_count <= fifo_count + FIFO_CNT_W'(r_valid) - FIFO_CNT_W'(pop);
    end
  end

  // queries in flight or buffered
  assign reserved_next = reserved + FIFO_CNT_W'(reserve) - FIFO_CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      reserved <= '0;
    end else begin
      reserved <= reserved_next;
    end
  end

  // checks
  `GPI_ASSERT_ALWAYS(a_credit_bound, reserved <= FIFO_CNT_W'(FIFO_DEPTH))
  `GPI_ASSERT_ALWAYS(a_buffer_within_credit, fifo_count <= reserved)
  `GPI_ASSERT_IMPLIES(a_no_overflow, r_valid, fifo_count != FIFO_CNT_W'(FIFO_DEPTH) || pop)
  `GPI_ASSERT_IMPLIES(a_step_only_inside_query, m_valid && m_step != '0, m_query && m_ok)

endmodule

// ----- tb/grid_potential_interpolator_unit_tb.sv -----
// Self-checking testbench for grid_potential_interpolator_unit: grid loads and point queries
// Depends on gpi_pkg and the unit RTL; results are predicted by an in-bench fixed-point model
module grid_potential_interpolator_unit_tb
  import gpi_pkg::*;
();

  localparam int GRID_T        = 8;
  localparam int GRID_X        = 64;
  localparam int GRID_Y        = 64;
  localparam int T_STRIDE      = GRID_X * GRID_Y;
  localparam int X_STRIDE      = GRID_Y;
  localparam int GRID_DEPTH    = 1 << ADDR_W;
  localparam int SETTLE_CYCLES = 24;
  localparam int DRAIN_LIMIT   = 4000;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_ITEMS   = 280;
  localparam int STEADY_ITEMS  = 180;
  localparam int RUN_LIMIT     = 5_000_000;

  // one full register setting; axis 0 is time, 1 is x, 2 is y
  typedef struct packed {
    logic [2:0][COORD_W-1:0] origin;
    logic [2:0][RECIP_W-1:0] recip;
    logic [LIMIT_W-1:0]      limit;
  } grid_setup_t;

  logic                  clk;
  logic                  rst;
  logic                  item_valid;
  logic                  item_stall;
  in_t                   item;
  logic                  result_valid;
  logic                  result_stall;
  out_t                  result;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // shadow registers, grid contents and pending results
  logic [2:0][COORD_W-1:0] origin_q = {ORIGIN_Y_RST, ORIGIN_X_RST, ORIGIN_TIME_RST};
  logic [2:0][RECIP_W-1:0] recip_q  = {RECIP_Y_RST, RECIP_X_RST, RECIP_TIME_RST};
  logic [LIMIT_W-1:0]      limit_q  = CLAMP_LIMIT_RST;
  logic signed [VAL_W-1:0] up_mem      [GRID_DEPTH];
  logic signed [VAL_W-1:0] down_mem    [GRID_DEPTH];
  logic signed [VAL_W-1:0] strange_mem [GRID_DEPTH];
  bit                      written     [GRID_DEPTH];
  out_t                    expected_potentials[$];
  out_t                    oldest;
  int                      fail_count = 0;
  int                      items_sent = 0;
  bit                      idling = 1'b1;

  grid_potential_interpolator_unit #(
    .GRID_T(GRID_T),
    .GRID_X(GRID_X),
    .GRID_Y(GRID_Y)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic flag_mismatch(input string what);
    fail_count++;
    $display("MISMATCH at %0t: %s", $time, what);
  endtask

  // coordinate to grid units: index and 16-bit fraction, false when off the grid
  function automatic bit split_axis(input logic signed [COORD_W-1:0] coord, origin,
                                    input logic [RECIP_W-1:0] recip, input int unsigned cells,
                                    output longint unsigned index,
                                    output logic [FRAC_W-1:0] frac);
    longint offset, scaled, step;
    step = longint'(recip);
    offset = longint'(coord) - longint'(origin);
    scaled = offset * step;
    index = 0;
    frac = '0;
    if (scaled < 0) return 1'b0;
    index = scaled >>> 32;
    frac = scaled[31:FRAC_W];
    return index < cells - 1;
  endfunction

  function automatic logic [ADDR_W-1:0] flat_addr(input longint unsigned t, x, y);
    longint unsigned a;
    a = t * T_STRIDE + x * X_STRIDE + y;
    return a[ADDR_W-1:0];
  endfunction

  // base point and the three forward neighbours of a query
  function automatic bit map_to_cell(input in_t beat, output logic [3:0][ADDR_W-1:0] corner,
                                     output logic [2:0][FRAC_W-1:0] frac);
    longint unsigned it, ix, iy;
    logic [FRAC_W-1:0] ft, fx, fy;
    bit ok;
    ok = split_axis(beat.query_time, origin_q[0], recip_q[0], GRID_T, it, ft);
    ok = split_axis(beat.query_x, origin_q[1], recip_q[1], GRID_X, ix, fx) && ok;
    ok = split_axis(beat.query_y, origin_q[2], recip_q[2], GRID_Y, iy, fy) && ok;
    frac = {fy, fx, ft};
    corner[0] = flat_addr(it, ix, iy);
    corner[1] = flat_addr(it + 1, ix, iy);
    corner[2] = flat_addr(it, ix + 1, iy);
    corner[3] = flat_addr(it, ix, iy + 1);
    return ok;
  endfunction

  // base plus fraction-weighted forward differences, rounded then clamped
  function automatic logic [VAL_W-1:0] first_order_blend(
      input logic signed [VAL_W-1:0] base, next_t, next_x, next_y,
      input logic [2:0][FRAC_W-1:0] frac);
    longint b, acc, lim, wt, wx, wy;
    b = longint'(base);
    wt = longint'(frac[0]);
    wx = longint'(frac[1]);
    wy = longint'(frac[2]);
    acc = b * ONE_Q16 + (longint'(next_t) - b) * wt + (longint'(next_x) - b) * wx
          + (longint'(next_y) - b) * wy;
    acc = (acc + ROUND_HALF) >>> FRAC_W;
    lim = longint'(limit_q);
    if (acc > lim) acc = lim;
    if (acc < -lim) acc = -lim;
    return acc[VAL_W-1:0];
  endfunction

  // update grid contents on a load, queue the expected potentials on a query
  function automatic void absorb_item(input in_t beat);
    logic [3:0][ADDR_W-1:0] corner;
    logic [2:0][FRAC_W-1:0] frac;
    out_t r;
    if (beat.kind == KIND_LOAD) begin
      up_mem[beat.entry_address] = beat.load_up;
      down_mem[beat.entry_address] = beat.load_down;
      strange_mem[beat.entry_address] = beat.load_strange;
      written[beat.entry_address] = 1'b1;
    end else begin
      r = '0;
      if (map_to_cell(beat, corner, frac)) begin
        r.result_up = first_order_blend(up_mem[corner[0]], up_mem[corner[1]],
                                        up_mem[corner[2]], up_mem[corner[3]], frac);
        r.result_down = first_order_blend(down_mem[corner[0]], down_mem[corner[1]],
                                          down_mem[corner[2]], down_mem[corner[3]], frac);
        r.result_strange = first_order_blend(strange_mem[corner[0]], strange_mem[corner[1]],
                                             strange_mem[corner[2]], strange_mem[corner[3]],
                                             frac);
        r.inside_grid = 1'b1;
      end
      expected_potentials.push_back(r);
    end
  endfunction

  function automatic in_t random_beat();
    in_t b;
    b.kind = kind_t'($urandom_range(0, 1));
    b.entry_address = ADDR_W'($urandom);
    b.load_up = VAL_W'($urandom);
    b.load_down = VAL_W'($urandom);
    b.load_strange = VAL_W'($urandom);
    b.query_time = $urandom;
    b.query_x = $urandom;
    b.query_y = $urandom;
    return b;
  endfunction

  // offset from the origin that lands on the grid, its last cell, or just past it
  function automatic logic [COORD_W-1:0] coord_inside(input logic [COORD_W-1:0] origin,
                                                      input logic [RECIP_W-1:0] recip,
                                                      input int unsigned cells);
    longint unsigned span, offset;
    offset = {$urandom, $urandom};
    if (recip != 0) begin
      span = cells - 1;
      span = (span << 32) / recip;
      case ($urandom_range(0, 11))
        0: offset = 0;
        1: offset = span - 1;
        2: offset = span + 1;
        default: offset = offset % span;
      endcase
    end
    return origin + offset[COORD_W-1:0];
  endfunction

  function automatic grid_setup_t typical_setup();
    grid_setup_t s;
    s.origin = {ORIGIN_Y_RST, ORIGIN_X_RST, ORIGIN_TIME_RST};
    s.recip = {RECIP_Y_RST, RECIP_X_RST, RECIP_TIME_RST};
    s.limit = '1;
    return s;
  endfunction

  function automatic grid_setup_t random_setup();
    grid_setup_t s;
    for (int a = 0; a < NUM_AXES; a++) begin
      case ($urandom_range(0, 9))
        0: s.origin[a] = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        1, 2: s.origin[a] = $urandom;
        default: s.origin[a] = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
      endcase
      case ($urandom_range(0, 9))
        0: s.recip[a] = '0;
        1: s.recip[a] = '1;
        2, 3: s.recip[a] = RECIP_W'($urandom);
        default: s.recip[a] = RECIP_W'($urandom_range(24'h00_4000, 24'h40_0000));
      endcase
    end
    case ($urandom_range(0, 9))
      0: s.limit = '0;
      1, 2, 3, 4: s.limit = '1;
      default: s.limit = LIMIT_W'($urandom);
    endcase
    return s;
  endfunction

  // one item beat, with an optional idle burst ahead of it
  task automatic send_item(input in_t beat);
    if (idling && $urandom_range(0, 3) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    item <= beat;
    item_valid <= 1'b1;
    @(posedge clk);
    while (item_stall !== 1'b0) @(posedge clk);
    absorb_item(beat);
    items_sent++;
  endtask

  // load any unwritten entry the query reads, then send the query
  task automatic send_query(input in_t beat);
    logic [3:0][ADDR_W-1:0] corner;
    logic [2:0][FRAC_W-1:0] frac;
    in_t fill;
    if (map_to_cell(beat, corner, frac)) begin
      for (int k = 0; k < NUM_SLOTS; k++) begin
        if (!written[corner[k]]) begin
          fill = random_beat();
          fill.kind = KIND_LOAD;
          fill.entry_address = corner[k];
          if ($urandom_range(0, 1)) begin
            fill.load_up = VAL_W'($urandom_range(0, 32'h3FFFF) - 32'h20000);
            fill.load_down = VAL_W'($urandom_range(0, 32'h3FFFF) - 32'h20000);
            fill.load_strange = VAL_W'($urandom_range(0, 32'h3FFFF) - 32'h20000);
          end
          send_item(fill);
        end
      end
    end
    send_item(beat);
  endtask

  task automatic send_load(input logic [ADDR_W-1:0] addr,
                           input logic [VAL_W-1:0] up, down, strange);
    in_t beat;
    beat = random_beat();
    beat.kind = KIND_LOAD;
    beat.entry_address = addr;
    beat.load_up = up;
    beat.load_down = down;
    beat.load_strange = strange;
    send_item(beat);
  endtask

  task automatic send_point(input logic [COORD_W-1:0] t, x, y);
    in_t beat;
    beat = random_beat();
    beat.kind = KIND_QUERY;
    beat.query_time = t;
    beat.query_x = x;
    beat.query_y = y;
    send_query(beat);
  endtask

  task automatic send_random_item();
    in_t beat;
    int pick;
    beat = random_beat();
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      beat.kind = KIND_QUERY;
      beat.query_time = coord_inside(origin_q[0], recip_q[0], GRID_T);
      beat.query_x = coord_inside(origin_q[1], recip_q[1], GRID_X);
      beat.query_y = coord_inside(origin_q[2], recip_q[2], GRID_Y);
      send_query(beat);
    end else if (pick < 85) begin
      beat.kind = KIND_QUERY;
      send_query(beat);
    end else begin
      beat.kind = KIND_LOAD;
      send_item(beat);
    end
  endtask

  // config beats back to back; valid drops only after the last one
  task automatic write_reg(input reg_index_t reg_index, input logic [CFG_DATA_W-1:0] data);
    cfg_index <= reg_index;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
  endtask

  task automatic program_setup(input grid_setup_t s);
    write_reg(REG_ORIGIN_TIME, s.origin[0]);
    write_reg(REG_ORIGIN_X, s.origin[1]);
    write_reg(REG_ORIGIN_Y, s.origin[2]);
    write_reg(REG_RECIP_TIME_STEP, CFG_DATA_W'(s.recip[0]));
    write_reg(REG_RECIP_X_STEP, CFG_DATA_W'(s.recip[1]));
    write_reg(REG_RECIP_Y_STEP, CFG_DATA_W'(s.recip[2]));
    write_reg(REG_CLAMP_LIMIT, CFG_DATA_W'(s.limit));
    cfg_valid <= 1'b0;
    origin_q = s.origin;
    recip_q = s.recip;
    limit_q = s.limit;
  endtask

  // wait for every pending result, then let trailing loads retire
  task automatic drain_results();
    int waited;
    item_valid <= 1'b0;
    waited = 0;
    while (expected_potentials.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (expected_potentials.size() != 0) begin
      flag_mismatch($sformatf("%0d results never arrived", expected_potentials.size()));
      expected_potentials.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // reset register values: exact base point, fractions, off-grid points, coordinate extremes
  task automatic test_default_setup();
    send_load(15'd0, 24'h7FFFFF, 24'h800000, 24'h000000);
    send_load(ADDR_W'(T_STRIDE), 24'h800000, 24'h7FFFFF, 24'h000100);
    send_load(ADDR_W'(X_STRIDE), 24'h000000, 24'h000001, 24'hFFFFFF);
    send_load(15'd1, 24'h123456, 24'hFEDCBA, 24'h00FFFF);
    send_load(15'h7FFF, 24'h555555, 24'hAAAAAA, 24'h7FFFFF);
    send_point(32'h0000_0000, 32'hFFF3_0000, 32'hFFF3_0000);
    send_point(32'h0000_0147, 32'hFFF3_0CCC, 32'hFFF3_1999);
    // one unit before the time origin
    send_point(32'hFFFF_FFFF, 32'hFFF3_0000, 32'hFFF3_0000);
    // past the last x cell with a forward neighbour
    send_point(32'h0000_0000, 32'hFFFA_0000, 32'hFFF3_0000);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    drain_results();
  endtask

  // zero and full-scale steps, extreme origins, zero and full clamp
  task automatic test_register_extremes();
    grid_setup_t s;
    s.origin = {3{32'h8000_0000}};
    s.recip = '0;
    s.limit = '1;
    program_setup(s);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_point($urandom, $urandom, $urandom);
    drain_results();
    s.origin = {3{32'h7FFF_FFFF}};
    s.recip = '1;
    s.limit = '0;
    program_setup(s);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    drain_results();
  endtask

  task automatic test_random_setups();
    int phase_end;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      program_setup(p == 0 ? typical_setup() : random_setup());
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) send_random_item();
      drain_results();
    end
  endtask

  // full rate on both sides, no idle beats
  task automatic test_steady_stream();
    int stream_end;
    idling = 1'b0;
    program_setup(typical_setup());
    stream_end = items_sent + STEADY_ITEMS;
    while (items_sent < stream_end) send_random_item();
    drain_results();
  endtask

  // receiver stall bursts
  initial begin
    result_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (idling && $urandom_range(0, 3) == 0) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
      result_stall <= 1'b0;
    end
  end

  // compare each accepted result beat with the oldest pending one
  always @(posedge clk) begin
    if (!rst && result_valid === 1'b1 && result_stall === 1'b0) begin
      if (expected_potentials.size() == 0) begin
        flag_mismatch("result beat with no query pending");
      end else begin
        oldest = expected_potentials.pop_front();
        if (result.result_up !== oldest.result_up)
          flag_mismatch($sformatf("result_up %h, want %h", result.result_up, oldest.result_up));
        if (result.result_down !== oldest.result_down)
          flag_mismatch($sformatf("result_down %h, want %h", result.result_down,
                                  oldest.result_down));
        if (result.result_strange !== oldest.result_strange)
          flag_mismatch($sformatf("result_strange %h, want %h", result.result_strange,
                                  oldest.result_strange));
        if (result.inside_grid !== oldest.inside_grid)
          flag_mismatch($sformatf("inside_grid %b, want %b", result.inside_grid,
                                  oldest.inside_grid));
      end
    end
  end

  initial begin
    rst <= 1'b1;
    item_valid <= 1'b0;
    item <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_default_setup();
    test_register_extremes();
    test_random_setups();
    test_steady_stream();
    if (fail_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  // run limit
  initial begin
    #(RUN_LIMIT);
    $display("Some tests failed");
    $finish;
  end

endmodule
